FILE: hdl/hprm_pkg.sv
// Shared types and constants for the Hall pulse rpm meter.
// Used by hprm_div and hall_pulse_rpm_meter_unit; no dependencies.
`default_nettype none

package hprm_pkg;

	// Microseconds per minute, the numerator of the speed formula.
	localparam logic [63:0] US_PER_MINUTE = 64'd60000000;
	// Bits needed to hold US_PER_MINUTE.
	localparam int unsigned US_PER_MINUTE_W = 26;

	localparam int unsigned TIMEOUT_W = 32;
	localparam int unsigned MAX_RPM_W = 12;
	localparam int unsigned RPM_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DAT_W = 32;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd500000;
	localparam logic [MAX_RPM_W-1:0] MAX_RPM_RESET = 12'd3000;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM = 1'b1;

	// Item kinds.
	localparam logic ACT_EDGE   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// Divider status toward the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: hdl/hprm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on hprm_pkg (div_stat_t).
`default_nettype none

module hprm_div #(
	parameter int unsigned N_W = 30,
	parameter int unsigned D_W = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [N_W-1:0]      numer,
	input  wire logic [D_W-1:0]      denom,
	output logic      [N_W-1:0]      quo,
	output logic                     rem_nz,
	output hprm_pkg::div_stat_t      stat
);
	import hprm_pkg::*;

	localparam int unsigned CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0]     rem_sh;
	logic [D_W:0]     rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[N_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Payload: shift in one quotient bit per step.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
		end
	end

	assign quo       = quo_q;
	assign rem_nz    = |rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: hdl/hall_pulse_rpm_meter_unit.sv
// Hall pulse rpm meter: period measurement and speed sampling.
// Depends on hprm_pkg and hprm_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: action selects a Hall
//   rising edge (0) or a speed sample (1), time_us is its microsecond stamp,
//   in_control is read on samples only. An edge item updates the last edge
//   time, and the stored period once an earlier edge exists; it gives no
//   result. A sample item gives one result on the output channel
//   (out_valid/out_ready): rpm_q4 is speed in rpm with FRAC_BITS fraction
//   bits, motor_stopped flags a stale or absent edge.
//   Sequencing: an edge item is handled in the idle state. A sample that
//   needs the speed goes from idle through the divide state, where the
//   restoring divider yields one quotient bit per cycle, to the finish
//   state, which writes the output register; the next item is taken once
//   the sequencer is back in idle. A sample reported as stopped, out of
//   control or with no period goes straight to the finish state.
//   in_ready is high only while the sequencer is idle, so one item is in
//   flight at a time.
//   The output register holds a finished result while the receiver stalls;
//   the block keeps taking edge items and starts the next sample meanwhile,
//   and only waits before writing a new result into a full output register.
//   Reset clears the edge stores, drops any pending result and loads
//   timeout_us = 500000 and max_rpm = 3000. Configuration writes
//   (cfg_we/cfg_index/cfg_data) take effect on the next clock edge.
`default_nettype none

module hall_pulse_rpm_meter_unit #(
	parameter int unsigned TIME_BITS = 32,
	parameter int unsigned FRAC_BITS = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [hprm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hprm_pkg::CFG_DAT_W-1:0]  cfg_data,
	// input items
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            action,
	input  wire logic [TIME_BITS-1:0]            time_us,
	input  wire logic                            in_control,
	// result items
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [hprm_pkg::RPM_W-1:0]      rpm_q4,
	output logic                                 motor_stopped
);
	import hprm_pkg::*;

	// Numerator of the speed quotient: 60e6 scaled by the fraction bits.
	localparam int unsigned NUM_W = US_PER_MINUTE_W + FRAC_BITS;
	localparam logic [NUM_W-1:0] NUMER = NUM_W'(US_PER_MINUTE) << FRAC_BITS;
	// Width for comparing an elapsed time against timeout_us.
	localparam int unsigned CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

	state_t                 state_q;

	logic [TIMEOUT_W-1:0]   timeout_q;
	logic [MAX_RPM_W-1:0]   max_rpm_q;

	logic [TIME_BITS-1:0]   last_edge_q;
	logic                   edge_valid_q;
	logic [TIME_BITS-1:0]   period_q;

	// Per-sample working state.
	logic                   zero_q;
	logic                   stopped_q;

	// Output register.
	logic                   out_valid_q;
	logic [RPM_W-1:0]       rpm_q;
	logic                   out_stopped_q;

	logic                   accept;
	logic                   is_sample;
	logic [TIME_BITS-1:0]   elapsed;
	logic                   stale;
	logic                   stopped_now;
	logic                   need_div;

	logic                   div_start;
	logic [NUM_W-1:0]       div_quo;
	logic                   div_rem_nz;
	div_stat_t              dstat;

	logic [NUM_W-1:0]       rpm_limit;
	logic                   capped;
	logic                   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_sample = (action == ACT_SAMPLE);

	// Age of the last edge, wrapping modulo 2^TIME_BITS.
	assign elapsed     = time_us - last_edge_q;
	assign stale       = CMP_W'(elapsed) > CMP_W'(timeout_q);
	assign stopped_now = !edge_valid_q || stale;
	// Divide only when a speed can come out of it.
	assign need_div    = in_control && !stopped_now && (period_q != '0);
	assign div_start   = accept && is_sample && need_div;

	hprm_div #(
		.N_W (NUM_W),
		.D_W (TIME_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (NUMER),
		.denom  (period_q),
		.quo    (div_quo),
		.rem_nz (div_rem_nz),
		.stat   (dstat)
	);

	// Speed exceeds max_rpm exactly when the scaled quotient passes the
	// scaled limit, or meets it with a nonzero remainder.
	assign rpm_limit = NUM_W'(max_rpm_q) << FRAC_BITS;
	assign capped    = (div_quo > rpm_limit) || ((div_quo == rpm_limit) && div_rem_nz);
	assign out_free  = !out_valid_q || out_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			max_rpm_q <= MAX_RPM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data[TIMEOUT_W-1:0];
				REG_MAX_RPM: max_rpm_q <= cfg_data[MAX_RPM_W-1:0];
				default: ;
			endcase
		end
	end

	// Edge stores and sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_edge_q  <= '0;
			edge_valid_q <= 1'b0;
			period_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !is_sample) begin
						// Edge: latch period once an earlier edge exists.
						if (edge_valid_q) begin
							period_q <= elapsed;
						end
						last_edge_q  <= time_us;
						edge_valid_q <= 1'b1;
					end else if (accept) begin
						// Sample out of control: drop both stores.
						if (!in_control) begin
							last_edge_q  <= '0;
							edge_valid_q <= 1'b0;
							period_q     <= '0;
						end
						state_q <= need_div ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (dstat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the sample's flags while the divider runs.
	always_ff @(posedge clk) begin
		if (accept && is_sample) begin
			zero_q    <= !need_div;
			stopped_q <= stopped_now;
		end
	end

	// Output register: advance when the slot is free, drop on take.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			rpm_q         <= (zero_q || capped) ? '0 : div_quo[RPM_W-1:0];
			out_stopped_q <= stopped_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign rpm_q4        = rpm_q;
	assign motor_stopped = out_stopped_q;

	// The divider only runs while the sequencer waits for it.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> (state_q == ST_DIV))
		else $error("divider busy outside ST_DIV");

	// The sequencer never waits on a divider that is not running.
	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dstat.busy || dstat.done))
		else $error("ST_DIV with idle divider");

	// A stopped motor always reports zero speed.
	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && motor_stopped) |-> (rpm_q4 == '0))
		else $error("nonzero rpm with motor stopped");

endmodule

`default_nettype wire
